// ----- sv/dsea_pkg.sv -----
// dsea_pkg: shared constants and codes for the daily solar energy accumulator
// used by the accumulator and its testbench; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package dsea_pkg;

    localparam int MAX_DAYS_DEF = 32;

    localparam int MODE_W  = 2;
    localparam int TS_W    = 48;
    localparam int DAY_W   = 16;
    localparam int WATT_W  = 17;
    localparam int MA_W    = 17;
    localparam int CV_W    = 14;
    localparam int PV_W    = 56;
    localparam int PROD_W  = 37;
    localparam int PEAK_W  = 16;
    localparam int CONS_W  = 64;
    localparam int CNT_W   = 6;
    localparam int THR_W   = 16;
    localparam int GAP_W   = 32;
    localparam int WIN_W   = 6;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;
    localparam int FAC_W   = 30;
    localparam int MUL_W   = FAC_W + GAP_W;
    localparam int SUM_W   = CONS_W + WIN_W;
    localparam int REM_W   = WIN_W + 1;
    localparam int DCNT_W  = 7;

    localparam logic [MODE_W-1:0] MODE_PV    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BATT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GAP_LIMIT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_AVG_WINDOW = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET = 16'd5;
    localparam logic [GAP_W-1:0] GAP_RESET = 32'd60000000;
    localparam logic [WIN_W-1:0] WIN_RESET = 6'd7;

endpackage
`default_nettype wire

// ----- sv/daily_solar_energy_accumulator.sv -----
// daily_solar_energy_accumulator: per-day pv energy, production time, peak and
// battery discharge, with a ring of closed days and window averages
// depends on dsea_pkg and dsea_ram
//
// usage: one input beat per item (valid/ready), one result beat per item.
// mode 0 is a pv sample, 1 a battery sample, 2 an average query, 3 does nothing.
// items are handled one at a time: o_in_ready is high only while the block idles.
// sample items pass through day check, interval and battery power product,
// multiply, saturating add and result load; an ignored item goes from the day
// check to the result load. the next item can be taken in the cycle after the result load.
// a query reads the closed-day rings through one read port, one entry a cycle,
// then runs a 70-step restoring divider; an empty window skips the ring read
// and the divider.
// the result sits in an output register, so a new item is accepted while an
// earlier result waits; when the receiver stalls, a finished item holds in the
// final state until the output register frees.
// reset (synchronous, active low) clears the accumulators, the ring pointer and
// count and loads the register defaults; ring contents are never cleared since
// only written entries are read.
// configuration writes take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none
module daily_solar_energy_accumulator #(
    parameter int MAX_DAYS = dsea_pkg::MAX_DAYS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dsea_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [dsea_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [dsea_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [dsea_pkg::TS_W-1:0]     i_timestamp_us,
    input  wire logic [dsea_pkg::DAY_W-1:0]    i_day_number,
    input  wire logic signed [dsea_pkg::WATT_W-1:0] i_pv_watts,
    input  wire logic signed [dsea_pkg::MA_W-1:0]   i_current_ma,
    input  wire logic signed [dsea_pkg::CV_W-1:0]   i_volts_centi,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [dsea_pkg::DAY_W-1:0]         o_today_day,
    output logic [dsea_pkg::PV_W-1:0]          o_today_pv_energy,
    output logic [dsea_pkg::PROD_W-1:0]        o_today_production_us,
    output logic [dsea_pkg::PEAK_W-1:0]        o_today_peak_watts,
    output logic [dsea_pkg::CONS_W-1:0]        o_today_consumption,
    output logic [dsea_pkg::CNT_W-1:0]         o_days_stored,
    output logic                               o_day_closed,
    output logic [dsea_pkg::PV_W-1:0]          o_avg_pv_energy,
    output logic [dsea_pkg::CONS_W-1:0]        o_avg_consumption
);
    import dsea_pkg::*;

    localparam int AW   = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
    localparam int CW   = $clog2(MAX_DAYS + 1);
    localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_DAYS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_DAYS);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MUL, S_ADD, S_RD, S_RDW, S_DIV, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [THR_W-1:0] r_thr;
    logic [GAP_W-1:0] r_gap;
    logic [WIN_W-1:0] r_win;

    // latched item
    logic [MODE_W-1:0]        r_mode;
    logic [TS_W-1:0]          r_ts;
    logic [DAY_W-1:0]         r_day;
    logic signed [WATT_W-1:0] r_watts;
    logic signed [MA_W-1:0]   r_ma;
    logic signed [CV_W-1:0]   r_cv;

    // day state
    logic [DAY_W-1:0]  r_cur_day;
    logic [PV_W-1:0]   r_pv_acc;
    logic [PROD_W-1:0] r_prod_acc;
    logic [PEAK_W-1:0] r_peak;
    logic [CONS_W-1:0] r_cons_acc;
    logic [TS_W-1:0]   r_last_pv;
    logic [TS_W-1:0]   r_last_batt;
    logic [AW-1:0]     r_ptr;
    logic [CW-1:0]     r_count;

    // work registers
    logic              r_ok;
    logic              r_over;
    logic              r_is_pv;
    logic [GAP_W-1:0]  r_dt;
    logic [FAC_W-1:0]  r_fac;
    logic [MUL_W-1:0]  r_prod;
    logic              r_closed;
    logic [WIN_W-1:0]  r_n;
    logic [WIN_W-1:0]  r_issued;
    logic [AW-1:0]     r_idx;
    logic              r_rd_v;
    logic [SUM_W-1:0]  r_sum_pv;
    logic [SUM_W-1:0]  r_sum_cs;
    logic [REM_W-1:0]  r_rem_pv;
    logic [REM_W-1:0]  r_rem_cs;
    logic [DCNT_W-1:0] r_dcnt;

    // output register
    logic              r_out_valid;
    logic [DAY_W-1:0]  r_o_day;
    logic [PV_W-1:0]   r_o_pv;
    logic [PROD_W-1:0] r_o_prod;
    logic [PEAK_W-1:0] r_o_peak;
    logic [CONS_W-1:0] r_o_cons;
    logic [CNT_W-1:0]  r_o_cnt;
    logic              r_o_closed;
    logic [PV_W-1:0]   r_o_avg_pv;
    logic [CONS_W-1:0] r_o_avg_cs;

    // combinational helpers
    logic              w_newday;
    logic              w_close;
    logic [TS_W-1:0]   w_last;
    logic [TS_W-1:0]   w_dt;
    logic              w_ok;
    logic [PEAK_W-1:0] w_watts_u;
    logic [PEAK_W-1:0] w_peak_base;
    logic              w_batt_take;
    logic [MA_W-1:0]   w_ma_mag;
    logic [CMPW-1:0]   w_cnt_x;
    logic [CMPW-1:0]   w_win_x;
    logic [WIN_W-1:0]  w_n;
    logic [CONS_W:0]   w_pv_sum;
    logic [PROD_W:0]   w_pt_sum;
    logic [CONS_W:0]   w_cs_sum;
    logic [REM_W-1:0]  w_rpv;
    logic [REM_W-1:0]  w_rcs;
    logic              w_qpv;
    logic              w_qcs;
    logic [PV_W-1:0]   w_rd_pv;
    logic [CONS_W-1:0] w_rd_cs;
    logic [AW-1:0]     w_ptr_prev;
    logic              w_ring_we;

    assign w_watts_u   = r_watts[PEAK_W-1:0];
    assign w_newday    = (r_day != r_cur_day);
    assign w_close     = w_newday && (r_pv_acc != '0) && (r_cur_day != '0);
    assign w_batt_take = r_ma[MA_W-1] && !r_cv[CV_W-1] && (r_cv != '0);
    assign w_ma_mag    = MA_W'(-r_ma);
    assign w_peak_base = w_newday ? '0 : r_peak;
    assign w_ptr_prev  = (r_ptr == '0) ? LAST_IDX : r_ptr - AW'(1);
    assign w_cnt_x     = CMPW'(r_count);
    assign w_win_x     = CMPW'(r_win);
    assign w_n         = (w_cnt_x < w_win_x) ? WIN_W'(w_cnt_x) : r_win;
    // a negative pv sample never closes the day
    assign w_ring_we   = (r_state == S_EXEC) && (r_mode == MODE_PV) && !r_watts[WATT_W-1]
                         && w_close;

    always_comb begin
        if (r_mode == MODE_PV) begin
            w_last = w_newday ? '0 : r_last_pv;
        end else begin
            w_last = r_last_batt;
        end
        w_dt = r_ts - w_last;
        w_ok = (w_last != '0) && (r_ts > w_last) && (w_dt[TS_W-1:GAP_W] == '0)
               && (w_dt[GAP_W-1:0] <= r_gap);
    end

    assign w_pv_sum = {{(CONS_W - PV_W + 1){1'b0}}, r_pv_acc}
                    + {{(CONS_W - MUL_W + 1){1'b0}}, r_prod};
    assign w_pt_sum = {1'b0, r_prod_acc} + {{(PROD_W - GAP_W + 1){1'b0}}, r_dt};
    assign w_cs_sum = {1'b0, r_cons_acc} + {{(CONS_W - MUL_W + 1){1'b0}}, r_prod};

    // one restoring step per cycle for both dividends
    always_comb begin
        w_rpv = {r_rem_pv[REM_W-2:0], r_sum_pv[SUM_W-1]};
        w_rcs = {r_rem_cs[REM_W-2:0], r_sum_cs[SUM_W-1]};
        w_qpv = (w_rpv >= {1'b0, r_n});
        w_qcs = (w_rcs >= {1'b0, r_n});
        if (w_qpv) begin
            w_rpv = w_rpv - {1'b0, r_n};
        end
        if (w_qcs) begin
            w_rcs = w_rcs - {1'b0, r_n};
        end
    end

    dsea_ram #(.WIDTH(PV_W), .DEPTH(MAX_DAYS)) u_ring_pv (
        .i_clk  (i_clk),
        .i_we   (w_ring_we),
        .i_waddr(r_ptr),
        .i_wdata(r_pv_acc),
        .i_raddr(r_idx),
        .o_rdata(w_rd_pv)
    );

    dsea_ram #(.WIDTH(CONS_W), .DEPTH(MAX_DAYS)) u_ring_cs (
        .i_clk  (i_clk),
        .i_we   (w_ring_we),
        .i_waddr(r_ptr),
        .i_wdata(r_cons_acc),
        .i_raddr(r_idx),
        .o_rdata(w_rd_cs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_gap       <= GAP_RESET;
            r_win       <= WIN_RESET;
            r_cur_day   <= '0;
            r_pv_acc    <= '0;
            r_prod_acc  <= '0;
            r_peak      <= '0;
            r_cons_acc  <= '0;
            r_last_pv   <= '0;
            r_last_batt <= '0;
            r_ptr       <= '0;
            r_count     <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_closed    <= 1'b0;
            r_n         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD:  r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_GAP_LIMIT:  r_gap <= i_cfg_data[GAP_W-1:0];
                    CFG_AVG_WINDOW: r_win <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_v <= 1'b0;
            if (r_rd_v) begin
                r_sum_pv <= r_sum_pv + {{(SUM_W - PV_W){1'b0}}, w_rd_pv};
                r_sum_cs <= r_sum_cs + {{(SUM_W - CONS_W){1'b0}}, w_rd_cs};
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode   <= i_mode;
                        r_ts     <= i_timestamp_us;
                        r_day    <= i_day_number;
                        r_watts  <= i_pv_watts;
                        r_ma     <= i_current_ma;
                        r_cv     <= i_volts_centi;
                        r_closed <= 1'b0;
                        r_n      <= '0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_ok <= w_ok;
                    r_dt <= w_dt[GAP_W-1:0];
                    r_state <= S_DONE;
                    if (r_mode == MODE_PV && !r_watts[WATT_W-1]) begin
                        if (w_newday) begin
                            if (w_close) begin
                                r_ptr    <= (r_ptr == LAST_IDX) ? '0 : r_ptr + AW'(1);
                                if (r_count != FULL_CNT) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_closed <= 1'b1;
                            end
                            r_pv_acc    <= '0;
                            r_prod_acc  <= '0;
                            r_cons_acc  <= '0;
                            r_cur_day   <= r_day;
                            r_last_batt <= '0;
                        end
                        r_last_pv <= r_ts;
                        r_peak    <= (w_watts_u > w_peak_base) ? w_watts_u : w_peak_base;
                        r_fac     <= FAC_W'(w_watts_u);
                        r_over    <= (w_watts_u > r_thr);
                        r_is_pv   <= 1'b1;
                        r_state   <= S_MUL;
                    end else if (r_mode == MODE_BATT && w_batt_take) begin
                        r_last_batt <= r_ts;
                        r_fac   <= FAC_W'(w_ma_mag) * FAC_W'(r_cv[CV_W-2:0]);
                        r_over  <= 1'b0;
                        r_is_pv <= 1'b0;
                        r_state <= S_MUL;
                    end else if (r_mode == MODE_QUERY) begin
                        r_n      <= w_n;
                        r_issued <= '0;
                        r_idx    <= w_ptr_prev;
                        r_sum_pv <= '0;
                        r_sum_cs <= '0;
                        if (w_n != '0) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= MUL_W'(r_fac) * MUL_W'(r_dt);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_ok) begin
                        if (r_is_pv) begin
                            r_pv_acc <= (w_pv_sum[CONS_W:PV_W] != '0) ? '1
                                                                       : w_pv_sum[PV_W-1:0];
                            if (r_over) begin
                                r_prod_acc <= w_pt_sum[PROD_W] ? '1 : w_pt_sum[PROD_W-1:0];
                            end
                        end else begin
                            r_cons_acc <= w_cs_sum[CONS_W] ? '1 : w_cs_sum[CONS_W-1:0];
                        end
                    end
                    r_state <= S_DONE;
                end
                S_RD: begin
                    // walk back from the newest closed day
                    r_rd_v   <= 1'b1;
                    r_issued <= r_issued + WIN_W'(1);
                    r_idx    <= (r_idx == '0) ? LAST_IDX : r_idx - AW'(1);
                    if (r_issued == r_n - WIN_W'(1)) begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    if (!r_rd_v) begin
                        r_rem_pv <= '0;
                        r_rem_cs <= '0;
                        r_dcnt   <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem_pv <= w_rpv;
                    r_rem_cs <= w_rcs;
                    r_sum_pv <= {r_sum_pv[SUM_W-2:0], w_qpv};
                    r_sum_cs <= {r_sum_cs[SUM_W-2:0], w_qcs};
                    r_dcnt   <= r_dcnt + DCNT_W'(1);
                    if (r_dcnt == DIV_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_day     <= r_cur_day;
                        r_o_pv      <= r_pv_acc;
                        r_o_prod    <= r_prod_acc;
                        r_o_peak    <= r_peak;
                        r_o_cons    <= r_cons_acc;
                        r_o_cnt     <= w_cnt_x[CNT_W-1:0];
                        r_o_closed  <= r_closed;
                        if (r_mode == MODE_QUERY && r_n != '0) begin
                            r_o_avg_pv <= r_sum_pv[PV_W-1:0];
                            r_o_avg_cs <= r_sum_cs[CONS_W-1:0];
                        end else begin
                            r_o_avg_pv <= '0;
                            r_o_avg_cs <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready            = (r_state == S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_today_day           = r_o_day;
    assign o_today_pv_energy     = r_o_pv;
    assign o_today_production_us = r_o_prod;
    assign o_today_peak_watts    = r_o_peak;
    assign o_today_consumption   = r_o_cons;
    assign o_days_stored         = r_o_cnt;
    assign o_day_closed          = r_o_closed;
    assign o_avg_pv_energy       = r_o_avg_pv;
    assign o_avg_consumption     = r_o_avg_cs;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("ring count beyond depth");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_n != '0))
        else $error("divide by zero window");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem_pv < {1'b0, r_n}) && (r_rem_cs < {1'b0, r_n}))
        else $error("divider remainder out of range");

    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_state == S_RD || r_state == S_RDW))
        else $error("ring read data outside walk");

endmodule
`default_nettype wire

// ----- sv/dsea_ram.sv -----
// dsea_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module dsea_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sim/daily_solar_energy_accumulator_tb.sv -----
// daily_solar_energy_accumulator_tb: self-checking bench with a queue-fed driver, a monitor
// and its own per-day accumulator predictor; depends on dsea_pkg and the block's rtl
`timescale 1ns / 1ps
module daily_solar_energy_accumulator_tb;
    import dsea_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RING_N = MAX_DAYS_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [TS_W-1:0]          ts;
        logic [DAY_W-1:0]         day;
        logic signed [WATT_W-1:0] watts;
        logic signed [MA_W-1:0]   ma;
        logic signed [CV_W-1:0]   cv;
    } t_sample;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [PV_W-1:0]   pv;
        logic [PROD_W-1:0] prod;
        logic [PEAK_W-1:0] peak;
        logic [CONS_W-1:0] cons;
        logic [CNT_W-1:0]  stored;
        logic              closed;
        logic [PV_W-1:0]   avg_pv;
        logic [CONS_W-1:0] avg_cons;
    } t_daily;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [MODE_W-1:0] i_mode = '0;
    logic [TS_W-1:0] i_timestamp_us = '0;
    logic [DAY_W-1:0] i_day_number = '0;
    logic signed [WATT_W-1:0] i_pv_watts = '0;
    logic signed [MA_W-1:0] i_current_ma = '0;
    logic signed [CV_W-1:0] i_volts_centi = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [DAY_W-1:0] o_today_day;
    logic [PV_W-1:0] o_today_pv_energy;
    logic [PROD_W-1:0] o_today_production_us;
    logic [PEAK_W-1:0] o_today_peak_watts;
    logic [CONS_W-1:0] o_today_consumption;
    logic [CNT_W-1:0] o_days_stored;
    logic o_day_closed;
    logic [PV_W-1:0] o_avg_pv_energy;
    logic [CONS_W-1:0] o_avg_consumption;

    daily_solar_energy_accumulator dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [THR_W-1:0]  thr_watts;
    logic [GAP_W-1:0]  gap_us;
    logic [WIN_W-1:0]  win_days;
    logic [DAY_W-1:0]  day_cur;
    logic [PV_W-1:0]   pv_acc;
    logic [PROD_W-1:0] prod_acc;
    logic [PEAK_W-1:0] peak_acc;
    logic [CONS_W-1:0] cons_acc;
    logic [TS_W-1:0]   pv_last_ts;
    logic [TS_W-1:0]   batt_last_ts;
    logic [PV_W-1:0]   hist_pv [RING_N];
    logic [CONS_W-1:0] hist_cons [RING_N];
    logic [4:0]        hist_wptr;
    logic [CNT_W-1:0]  hist_count;

    t_sample pending_samples[$];
    t_daily  expected_days[$];
    bit failed = 0;
    bit beat_taken = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    // generator state for the random sample sequences
    logic [TS_W-1:0]  gen_ts;
    logic [DAY_W-1:0] gen_day;
    longint unsigned  gen_step_max;
    int               gen_newday_pct;

    function automatic bit interval_ok(logic [TS_W-1:0] last, logic [TS_W-1:0] now,
                                       output logic [TS_W-1:0] dt);
        dt = now - last;
        return last != '0 && now > last && dt <= {16'd0, gap_us};
    endfunction

    function automatic logic [CONS_W-1:0] window_mean(bit use_pv, int n);
        logic [SUM_W-1:0] sum;
        logic [4:0] idx;
        sum = '0;
        if (n == 0) return '0;
        for (int i = 0; i < n; i++) begin
            idx = hist_wptr - 5'd1 - 5'(i);
            sum += use_pv ? SUM_W'(hist_pv[idx]) : SUM_W'(hist_cons[idx]);
        end
        return CONS_W'(sum / n);
    endfunction

    function automatic t_daily solar_day_step(t_sample s);
        t_daily r;
        logic [TS_W-1:0] dt;
        logic [PEAK_W-1:0] w;
        logic [64:0] sum;
        logic [63:0] pwr;
        int n;
        r = '0;
        if (s.mode == MODE_PV && s.watts >= 0) begin
            w = s.watts[15:0];
            if (s.day != day_cur) begin
                if (pv_acc != '0 && day_cur != '0) begin
                    hist_pv[hist_wptr] = pv_acc;
                    hist_cons[hist_wptr] = cons_acc;
                    hist_wptr++;
                    if (hist_count < RING_N) hist_count++;
                    r.closed = 1'b1;
                end
                pv_acc = '0;
                prod_acc = '0;
                peak_acc = '0;
                cons_acc = '0;
                day_cur = s.day;
                pv_last_ts = '0;
                batt_last_ts = '0;
            end
            if (interval_ok(pv_last_ts, s.ts, dt)) begin
                sum = 65'(pv_acc) + 65'(64'(w) * 64'(dt));
                pv_acc = sum > 65'({PV_W{1'b1}}) ? {PV_W{1'b1}} : sum[PV_W-1:0];
                if (w > thr_watts) begin
                    sum = 65'(prod_acc) + 65'(dt);
                    prod_acc = sum > 65'({PROD_W{1'b1}}) ? {PROD_W{1'b1}} : sum[PROD_W-1:0];
                end
            end
            pv_last_ts = s.ts;
            if (w > peak_acc) peak_acc = w;
        end else if (s.mode == MODE_BATT && s.ma < 0 && s.cv > 0) begin
            if (interval_ok(batt_last_ts, s.ts, dt)) begin
                pwr = 64'(-64'(s.ma)) * 64'(s.cv);
                sum = 65'(cons_acc) + 65'(pwr * 64'(dt));
                cons_acc = sum[64] ? '1 : sum[63:0];
            end
            batt_last_ts = s.ts;
        end else if (s.mode == MODE_QUERY) begin
            n = hist_count < win_days ? hist_count : win_days;
            r.avg_pv = PV_W'(window_mean(1, n));
            r.avg_cons = window_mean(0, n);
        end
        r.day = day_cur;
        r.pv = pv_acc;
        r.prod = prod_acc;
        r.peak = peak_acc;
        r.cons = cons_acc;
        r.stored = hist_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1;
        end
    endtask

    // monitor: input beats feed the predictor, output beats are checked
    always @(posedge i_clk) begin
        t_daily e;
        beat_taken = i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (beat_taken)
                expected_days.push_back(solar_day_step({i_mode, i_timestamp_us, i_day_number,
                    i_pv_watts, i_current_ma, i_volts_centi}));
            if (o_out_valid && i_out_ready) begin
                if (expected_days.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1;
                end else begin
                    e = expected_days.pop_front();
                    check_field("today_day", e.day, o_today_day);
                    check_field("today_pv_energy", e.pv, o_today_pv_energy);
                    check_field("today_production_us", e.prod, o_today_production_us);
                    check_field("today_peak_watts", e.peak, o_today_peak_watts);
                    check_field("today_consumption", e.cons, o_today_consumption);
                    check_field("days_stored", e.stored, o_days_stored);
                    check_field("day_closed", e.closed, o_day_closed);
                    check_field("avg_pv_energy", e.avg_pv, o_avg_pv_energy);
                    check_field("avg_consumption", e.avg_cons, o_avg_consumption);
                end
            end
            if (beat_taken || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_sample s;
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s = pending_samples.pop_front();
                i_mode <= s.mode;
                i_timestamp_us <= s.ts;
                i_day_number <= s.day;
                i_pv_watts <= s.watts;
                i_current_ma <= s.ma;
                i_volts_centi <= s.cv;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 600;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n && $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    task automatic add_sample(logic [MODE_W-1:0] m, logic [TS_W-1:0] ts, logic [DAY_W-1:0] d,
                              int w, int ma, int cv);
        pending_samples.push_back({m, ts, d, WATT_W'(w), MA_W'(ma), CV_W'(cv)});
    endtask

    task automatic add_random_sample();
        int pick;
        logic [MODE_W-1:0] m;
        logic [TS_W-1:0] ts;
        int w, ma, cv;
        pick = $urandom_range(0, 99);
        m = pick < 48 ? MODE_PV : pick < 83 ? MODE_BATT : pick < 96 ? MODE_QUERY : MODE_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            gen_ts += TS_W'($urandom_range(1, 1000)) +
                      TS_W'(gen_step_max > 1000 ? {$urandom, $urandom} % gen_step_max : 0);
            ts = gen_ts;
        end else if (pick < 89) begin
            ts = gen_ts;
        end else if (pick < 92) begin
            ts = gen_ts - TS_W'($urandom_range(1, 100000));
        end else if (pick < 94) begin
            ts = '0;
        end else if (pick < 97) begin
            gen_ts += TS_W'(gen_step_max) + TS_W'($urandom_range(1, 1000));
            ts = gen_ts;
        end else begin
            gen_ts = TS_W'({$urandom, $urandom});
            ts = gen_ts;
        end
        if (m == MODE_PV && $urandom_range(0, 99) < gen_newday_pct) begin
            pick = $urandom_range(0, 19);
            gen_day = pick == 0 ? '0 : pick == 1 ? DAY_W'($urandom) : gen_day + 1'b1;
        end
        w = $urandom_range(0, 9) == 0 ? -int'($urandom_range(1, 65536)) :
            $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 600);
        ma = $urandom_range(0, 5) == 0 ? $urandom_range(0, 65535) :
             -int'($urandom_range(1, 65536));
        cv = $urandom_range(0, 7) == 0 ? -int'($urandom_range(0, 8192)) :
             $urandom_range(1, 8191);
        add_sample(m, ts, gen_day, w, ma, cv);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD:  thr_watts = val[THR_W-1:0];
            CFG_GAP_LIMIT:  gap_us = val;
            CFG_AVG_WINDOW: win_days = val[WIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_days.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int thr, longint unsigned gap, int win, int count, int newday_pct);
        write_reg(CFG_THRESHOLD, CFG_W'(thr));
        write_reg(CFG_GAP_LIMIT, CFG_W'(gap));
        write_reg(CFG_AVG_WINDOW, CFG_W'(win));
        gen_step_max = gap;
        gen_newday_pct = newday_pct;
        repeat (count) add_random_sample();
        drain();
    endtask

    initial begin
        thr_watts = THR_RESET;
        gap_us = GAP_RESET;
        win_days = WIN_RESET;
        day_cur = '0;
        pv_acc = '0;
        prod_acc = '0;
        peak_acc = '0;
        cons_acc = '0;
        pv_last_ts = '0;
        batt_last_ts = '0;
        hist_wptr = '0;
        hist_count = '0;
        gen_ts = 48'd1000;
        gen_day = 16'd10;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: register defaults
        send_idle_pct = 38;
        recv_idle_pct = 56;
        add_sample(MODE_QUERY, 48'd5, 16'd0, 0, 0, 0);
        add_sample(MODE_PV, 48'd1000, 16'd1, 10, 0, 0);
        add_sample(MODE_PV, 48'd2000, 16'd1, 100, 0, 0);
        add_sample(MODE_PV, 48'd2000, 16'd1, 3, 0, 0);
        add_sample(MODE_PV, 48'd1500, 16'd1, 5, 0, 0);
        add_sample(MODE_PV, 48'd60001501, 16'd1, 6, 0, 0);
        add_sample(MODE_PV, 48'd60002000, 16'd1, -65536, 0, 0);
        add_sample(MODE_BATT, 48'd5000, 16'd7, 0, -65536, 8191);
        add_sample(MODE_BATT, 48'd6000, 16'd7, 0, -1, 1);
        add_sample(MODE_BATT, 48'd7000, 16'd7, 0, 65535, 100);
        add_sample(MODE_BATT, 48'd8000, 16'd7, 0, -100, 0);
        add_sample(MODE_BATT, 48'd9000, 16'd7, 0, -100, -8192);
        add_sample(MODE_UNUSED, '0, 16'hFFFF, -1, -1, -1);
        add_sample(MODE_PV, '0, 16'd1, 65535, 0, 0);
        add_sample(MODE_PV, 48'd100, 16'd1, 7, 0, 0);
        add_sample(MODE_PV, 48'd200, 16'd2, 50, 0, 0);
        add_sample(MODE_PV, 48'd300, 16'd2, 50, 0, 0);
        add_sample(MODE_PV, 48'd400, 16'd0, 20, 0, 0);
        add_sample(MODE_PV, 48'd500, 16'd0, 20, 0, 0);
        add_sample(MODE_PV, 48'd600, 16'd5, 20, 0, 0);
        add_sample(MODE_QUERY, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 65535, 65535, 8191);
        add_sample(MODE_PV, 48'hFFFF_FFFF_FFFE, 16'hFFFF, 65535, 0, 0);
        add_sample(MODE_PV, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 65535, 0, 0);
        drain();

        run_phase(5, 60000000, 7, 250, 8);
        run_phase(0, 1, 1, 150, 8);
        send_idle_pct = 56;
        recv_idle_pct = 38;
        run_phase(65535, 64'hFFFF_FFFF, 32, 300, 2);
        run_phase($urandom_range(0, 700), $urandom_range(1000, 2000000), 63, 250, 10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1;
        run_phase(300, 5000000, 0, 250, 10);
        run_phase($urandom_range(0, 65535), $urandom, 32, 330, 6);

        drain();
        if (!failed && expected_days.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
